[design/trsm_pkg.sv]
// ============================================================================
// trsm_pkg
// Shared types and constants for the TRS-to-matrix pipeline.
// ============================================================================
package trsm_pkg;

    // Input beat: rotation quaternion (Q1.14), scale (Q8.8), translation (Q16.16)
    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] scale_z;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } in_beat_t;

    // Output beat: twelve non-constant matrix entries, Q16.16
    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] m30;
        logic signed [31:0] m31;
        logic signed [31:0] m32;
    } out_beat_t;

    // Arithmetic widths
    localparam int QUAT_W  = 16;
    localparam int LANES   = 4;                 // x, y, z, w
    localparam int LEN_W   = 33;                // sum of squares, Q5.28
    localparam int RAD_W   = 64;                // radicand len << 30
    localparam int ROOT_W  = 32;                // floor sqrt
    localparam int NUM_W   = 61;                // |q| << 45 plus rounding
    localparam int QUO_W   = 32;                // normalized magnitude
    localparam int NORM_W  = 32;                // signed Q2.30
    localparam int PROD_W  = 2 * NORM_W;        // Q.60 products
    localparam int SUM_W   = PROD_W + 2;
    localparam int BIAS_W  = SUM_W + 2;
    localparam int R30_W   = 34;                // rotation entry, Q.30
    localparam int SCL_W   = QUAT_W + R30_W;    // scale * rotation, Q.38
    localparam int OUT_W   = 32;
    localparam int MAT_N   = 9;

    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int QUAT_W_IDX = 3;              // lane holding w

    // Pipeline stage numbers (register index of each result)
    localparam int ST_SQ   = 1;
    localparam int ST_LEN  = 2;
    localparam int ST_ROOT = ST_LEN + SQRT_STEPS;
    localparam int ST_NUM  = ST_ROOT + 1;
    localparam int ST_QUO  = ST_NUM + DIV_STEPS;
    localparam int ST_NORM = ST_QUO + 1;
    localparam int ST_PROD = ST_NORM + 1;
    localparam int ST_SUM  = ST_PROD + 1;
    localparam int ST_R30  = ST_SUM + 1;
    localparam int ST_SCL  = ST_R30 + 1;
    localparam int LAT     = ST_SCL + 1;

    // Rounding constants
    localparam logic signed [BIAS_W-1:0] DIAG_BIAS = BIAS_W'((64'd1 << 60) + (64'd1 << 29));
    localparam logic signed [BIAS_W-1:0] R_HALF    = BIAS_W'(64'd1 << 29);
    localparam logic signed [SCL_W-1:0]  OUT_HALF  = SCL_W'(64'd1 << 21);
    localparam logic signed [NORM_W-1:0] ONE_Q30   = NORM_W'(64'd1 << 30);

endpackage

[design/trsm_isqrt.sv]
// ============================================================================
// trsm_isqrt
// Pipelined integer square root, one result bit per stage.
// ============================================================================
module trsm_isqrt (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [trsm_pkg::RAD_W-1:0]    rad,
    output logic [trsm_pkg::ROOT_W-1:0]   root
);
    localparam int STEPS = trsm_pkg::SQRT_STEPS;
    localparam int RW    = trsm_pkg::RAD_W;
    localparam int REM_W = STEPS + 4;

    logic [RW-1:0]    rad_reg  [1:STEPS-1];
    logic [REM_W-1:0] rem_reg  [1:STEPS-1];
    logic [STEPS-1:0] root_reg [1:STEPS];

    logic [RW-1:0]    rad_in   [0:STEPS-1];
    logic [REM_W-1:0] rem_in   [0:STEPS-1];
    logic [STEPS-1:0] root_in  [0:STEPS-1];
    logic [REM_W-1:0] cur      [0:STEPS-1];
    logic [REM_W-1:0] trial    [0:STEPS-1];
    logic             ge       [0:STEPS-1];

    // Stage inputs: first stage from the port, others from registers
    always_comb begin
        rad_in[0]  = rad;
        rem_in[0]  = '0;
        root_in[0] = '0;
        for (int k = 1; k < STEPS; k++) begin
            rad_in[k]  = rad_reg[k];
            rem_in[k]  = rem_reg[k];
            root_in[k] = root_reg[k];
        end
    end

    // Trial subtract per stage; each stage is independent
    always_comb begin
        for (int k = 0; k < STEPS; k++) begin
            cur[k]   = {rem_in[k][REM_W-3:0], rad_in[k][RW-1 -: 2]};
            trial[k] = {{(REM_W-STEPS-2){1'b0}}, root_in[k], 2'b01};
            ge[k]    = (cur[k] >= trial[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < STEPS - 1; k++) begin
                rad_reg[k+1] <= rad_in[k] << 2;
                rem_reg[k+1] <= ge[k] ? (cur[k] - trial[k]) : cur[k];
            end
            for (int k = 0; k < STEPS; k++) begin
                root_reg[k+1] <= {root_in[k][STEPS-2:0], ge[k]};
            end
        end
    end

    assign root = root_reg[STEPS];

endmodule

[design/trsm_div.sv]
// ============================================================================
// trsm_div
// Pipelined restoring divider, four lanes sharing one divisor,
// one quotient bit per stage.
// ============================================================================
module trsm_div (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [trsm_pkg::NUM_W-1:0]    num [trsm_pkg::LANES],
    input  logic [trsm_pkg::ROOT_W-1:0]   den,
    output logic [trsm_pkg::QUO_W-1:0]    quo [trsm_pkg::LANES]
);
    localparam int STEPS = trsm_pkg::DIV_STEPS;
    localparam int NL    = trsm_pkg::LANES;
    localparam int DW    = trsm_pkg::ROOT_W;
    localparam int QW    = trsm_pkg::QUO_W;
    localparam int NW    = trsm_pkg::NUM_W;

    // qn holds the unused dividend bits on top and the quotient bits below
    logic [DW-1:0] den_reg [1:STEPS-1];
    logic [DW-1:0] rem_reg [1:STEPS-1][NL];
    logic [QW-1:0] qn_reg  [1:STEPS][NL];

    logic [DW-1:0] den_in  [0:STEPS-1];
    logic [DW-1:0] rem_in  [0:STEPS-1][NL];
    logic [QW-1:0] qn_in   [0:STEPS-1][NL];
    logic [DW:0]   cur     [0:STEPS-1][NL];
    logic          ge      [0:STEPS-1][NL];

    // Stage inputs
    always_comb begin
        den_in[0] = den;
        for (int l = 0; l < NL; l++) begin
            rem_in[0][l] = DW'(num[l][NW-1:QW]);
            qn_in[0][l]  = num[l][QW-1:0];
        end
        for (int k = 1; k < STEPS; k++) begin
            den_in[k] = den_reg[k];
            for (int l = 0; l < NL; l++) begin
                rem_in[k][l] = rem_reg[k][l];
                qn_in[k][l]  = qn_reg[k][l];
            end
        end
    end

    // Compare and subtract per stage and lane
    always_comb begin
        for (int k = 0; k < STEPS; k++) begin
            for (int l = 0; l < NL; l++) begin
                cur[k][l] = {rem_in[k][l], qn_in[k][l][QW-1]};
                ge[k][l]  = (cur[k][l] >= {1'b0, den_in[k]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < STEPS - 1; k++) begin
                den_reg[k+1] <= den_in[k];
                for (int l = 0; l < NL; l++) begin
                    rem_reg[k+1][l] <= ge[k][l] ? DW'(cur[k][l] - {1'b0, den_in[k]})
                                                : DW'(cur[k][l]);
                end
            end
            for (int k = 0; k < STEPS; k++) begin
                for (int l = 0; l < NL; l++) begin
                    qn_reg[k+1][l] <= {qn_in[k][l][QW-2:0], ge[k][l]};
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            quo[l] = qn_reg[STEPS][l];
        end
    end

endmodule

[design/trs_to_matrix.sv]
// ============================================================================
// trs_to_matrix
// Rotation / scale / translation to 4x4 row-vector transform matrix.
// ============================================================================
// Usage:
//   s_data carries one transform (quaternion Q1.14, scale Q8.8, translation
//   Q16.16) per beat on a valid/ready channel; m_data returns the twelve
//   non-constant matrix entries (Q16.16), one beat per input beat, in order.
//   Column 3 is always (0,0,0,1) and is not sent.
// Depth: 73 register stages. The length's square root (32 stages, one root
//   bit each) and the normalizing divide (32 stages, one quotient bit each)
//   set the depth.
// Throughput: one beat per cycle while no result is held back by m_ready low.
// A zero-length quaternion is replaced by the identity rotation.
// Reset (aresetn low, synchronous) empties the pipeline; no results are
//   pending afterwards.
// When the receiver holds m_ready low with a result waiting, the whole
//   pipeline freezes and s_ready drops; nothing is lost or repeated.
//   Bubbles inside the pipeline are not squeezed out during such a stall.
// ============================================================================
module trs_to_matrix (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  trsm_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output trsm_pkg::out_beat_t  m_data
);
    localparam int LAT  = trsm_pkg::LAT;
    localparam int NL   = trsm_pkg::LANES;
    localparam int NMAT = trsm_pkg::MAT_N;
    localparam int SQ_W = 2 * trsm_pkg::QUAT_W;

    logic                              en;
    logic [LAT:1]                      vld_reg;
    trsm_pkg::in_beat_t                side_reg [1:LAT-1];

    logic [SQ_W-1:0]                   sq_reg   [NL];
    logic [trsm_pkg::LEN_W-1:0]        len_reg;
    logic [trsm_pkg::ROOT_W-1:0]       root;
    logic [trsm_pkg::NUM_W-1:0]        num_reg  [NL];
    logic [trsm_pkg::ROOT_W-1:0]       den_reg;
    logic [trsm_pkg::QUO_W-1:0]        quo      [NL];
    logic signed [trsm_pkg::NORM_W-1:0] n_reg   [NL];
    logic signed [trsm_pkg::PROD_W-1:0] pxx_reg, pyy_reg, pzz_reg, pxy_reg, pzw_reg;
    logic signed [trsm_pkg::PROD_W-1:0] pxz_reg, pyw_reg, pyz_reg, pxw_reg;
    logic signed [trsm_pkg::SUM_W-1:0]  sum_reg [NMAT];
    logic signed [trsm_pkg::R30_W-1:0]  r30_reg [NMAT];
    logic signed [trsm_pkg::SCL_W-1:0]  scl_reg [NMAT];
    trsm_pkg::out_beat_t                m_data_reg;

    logic signed [trsm_pkg::QUAT_W-1:0] q_in   [NL];
    logic signed [trsm_pkg::QUAT_W-1:0] q_root [NL];
    logic signed [trsm_pkg::QUAT_W-1:0] q_quo  [NL];
    logic [trsm_pkg::QUAT_W-1:0]        mag    [NL];
    logic                               q_zero;
    logic signed [trsm_pkg::BIAS_W-1:0] rbias  [NMAT];
    logic signed [trsm_pkg::QUAT_W-1:0] srow   [NMAT];
    logic signed [trsm_pkg::SCL_W-1:0]  rnd    [NMAT];
    logic signed [trsm_pkg::OUT_W-1:0]  ent    [NMAT];

    // Global advance: the pipeline moves unless a finished beat is blocked
    assign en      = !vld_reg[LAT] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT];
    assign m_data  = m_data_reg;

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-1:1], s_valid};
        end
    end

    // Side-band copy of the input beat
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[1] <= s_data;
            for (int k = 2; k < LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Quaternion components at the stages that use them
    always_comb begin
        q_in[0]   = s_data.quat_x;
        q_in[1]   = s_data.quat_y;
        q_in[2]   = s_data.quat_z;
        q_in[3]   = s_data.quat_w;
        q_root[0] = side_reg[trsm_pkg::ST_ROOT].quat_x;
        q_root[1] = side_reg[trsm_pkg::ST_ROOT].quat_y;
        q_root[2] = side_reg[trsm_pkg::ST_ROOT].quat_z;
        q_root[3] = side_reg[trsm_pkg::ST_ROOT].quat_w;
        q_quo[0]  = side_reg[trsm_pkg::ST_QUO].quat_x;
        q_quo[1]  = side_reg[trsm_pkg::ST_QUO].quat_y;
        q_quo[2]  = side_reg[trsm_pkg::ST_QUO].quat_z;
        q_quo[3]  = side_reg[trsm_pkg::ST_QUO].quat_w;
        q_zero    = (q_quo[0] == '0) && (q_quo[1] == '0)
                 && (q_quo[2] == '0) && (q_quo[3] == '0);
        for (int l = 0; l < NL; l++) begin
            mag[l] = q_root[l][trsm_pkg::QUAT_W-1] ? (~q_root[l] + 1'b1) : q_root[l];
        end
    end

    // Squares (operands widened first), then length
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < NL; l++) begin
                sq_reg[l] <= $unsigned(SQ_W'(q_in[l]) * SQ_W'(q_in[l]));
            end
            len_reg <= trsm_pkg::LEN_W'(sq_reg[0]) + trsm_pkg::LEN_W'(sq_reg[1])
                     + trsm_pkg::LEN_W'(sq_reg[2]) + trsm_pkg::LEN_W'(sq_reg[3]);
        end
    end

    // S = floor(sqrt(len << 30))
    trsm_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .rad  ({1'b0, len_reg, 30'b0}),
        .root (root)
    );

    // Dividend with half-divisor rounding
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= root;
            for (int l = 0; l < NL; l++) begin
                num_reg[l] <= {mag[l], 45'b0} + trsm_pkg::NUM_W'(root >> 1);
            end
        end
    end

    trsm_div u_div (
        .aclk (aclk),
        .en   (en),
        .num  (num_reg),
        .den  (den_reg),
        .quo  (quo)
    );

    // Apply sign, substitute identity for a zero quaternion
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < NL; l++) begin
                if (q_zero) begin
                    n_reg[l] <= (l == trsm_pkg::QUAT_W_IDX) ? trsm_pkg::ONE_Q30 : '0;
                end else if (q_quo[l][trsm_pkg::QUAT_W-1]) begin
                    n_reg[l] <= -$signed(quo[l]);
                end else begin
                    n_reg[l] <= $signed(quo[l]);
                end
            end
        end
    end

    // Q.60 products
    always_ff @(posedge aclk) begin
        if (en) begin
            pxx_reg <= n_reg[0] * n_reg[0];
            pyy_reg <= n_reg[1] * n_reg[1];
            pzz_reg <= n_reg[2] * n_reg[2];
            pxy_reg <= n_reg[0] * n_reg[1];
            pzw_reg <= n_reg[2] * n_reg[3];
            pxz_reg <= n_reg[0] * n_reg[2];
            pyw_reg <= n_reg[1] * n_reg[3];
            pyz_reg <= n_reg[1] * n_reg[2];
            pxw_reg <= n_reg[0] * n_reg[3];
        end
    end

    // Pair sums for each rotation entry
    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg[0] <= trsm_pkg::SUM_W'(pyy_reg) + trsm_pkg::SUM_W'(pzz_reg);
            sum_reg[1] <= trsm_pkg::SUM_W'(pxy_reg) + trsm_pkg::SUM_W'(pzw_reg);
            sum_reg[2] <= trsm_pkg::SUM_W'(pxz_reg) - trsm_pkg::SUM_W'(pyw_reg);
            sum_reg[3] <= trsm_pkg::SUM_W'(pxy_reg) - trsm_pkg::SUM_W'(pzw_reg);
            sum_reg[4] <= trsm_pkg::SUM_W'(pxx_reg) + trsm_pkg::SUM_W'(pzz_reg);
            sum_reg[5] <= trsm_pkg::SUM_W'(pyz_reg) + trsm_pkg::SUM_W'(pxw_reg);
            sum_reg[6] <= trsm_pkg::SUM_W'(pxz_reg) + trsm_pkg::SUM_W'(pyw_reg);
            sum_reg[7] <= trsm_pkg::SUM_W'(pyz_reg) - trsm_pkg::SUM_W'(pxw_reg);
            sum_reg[8] <= trsm_pkg::SUM_W'(pxx_reg) + trsm_pkg::SUM_W'(pyy_reg);
        end
    end

    // Rotation entry, rounded to Q.30 (floor shift of the biased value)
    always_comb begin
        for (int i = 0; i < NMAT; i++) begin
            if (i == 0 || i == 4 || i == 8) begin
                rbias[i] = trsm_pkg::DIAG_BIAS - (trsm_pkg::BIAS_W'(sum_reg[i]) <<< 1);
            end else begin
                rbias[i] = (trsm_pkg::BIAS_W'(sum_reg[i]) <<< 1) + trsm_pkg::R_HALF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NMAT; i++) begin
                r30_reg[i] <= rbias[i][30 +: trsm_pkg::R30_W];
            end
        end
    end

    // Scale by row
    always_comb begin
        for (int i = 0; i < NMAT; i++) begin
            if (i < 3) begin
                srow[i] = side_reg[trsm_pkg::ST_R30].scale_x;
            end else if (i < 6) begin
                srow[i] = side_reg[trsm_pkg::ST_R30].scale_y;
            end else begin
                srow[i] = side_reg[trsm_pkg::ST_R30].scale_z;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NMAT; i++) begin
                scl_reg[i] <= srow[i] * r30_reg[i];
            end
        end
    end

    // Round to Q16.16; the rounded value spans 28 bits, so it never saturates
    always_comb begin
        for (int i = 0; i < NMAT; i++) begin
            rnd[i] = scl_reg[i] + trsm_pkg::OUT_HALF;
            ent[i] = trsm_pkg::OUT_W'($signed(rnd[i][trsm_pkg::SCL_W-1:22]));
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.m00 <= ent[0];
            m_data_reg.m01 <= ent[1];
            m_data_reg.m02 <= ent[2];
            m_data_reg.m10 <= ent[3];
            m_data_reg.m11 <= ent[4];
            m_data_reg.m12 <= ent[5];
            m_data_reg.m20 <= ent[6];
            m_data_reg.m21 <= ent[7];
            m_data_reg.m22 <= ent[8];
            m_data_reg.m30 <= side_reg[trsm_pkg::ST_SCL].trans_x;
            m_data_reg.m31 <= side_reg[trsm_pkg::ST_SCL].trans_y;
            m_data_reg.m32 <= side_reg[trsm_pkg::ST_SCL].trans_z;
        end
    end

endmodule

[design/trsm_checker.sv]
// ============================================================================
// trsm_checker
// Port-level checks for trs_to_matrix, attached by bind.
// ============================================================================
module trsm_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input trsm_pkg::out_beat_t  m_data
);
    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A blocked result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Input side stalls exactly when a result is blocked
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output stall");

    // A beat taken while stalled would be lost: input cannot advance then
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && m_valid && !m_ready |-> !s_ready)
        else $error("input beat taken while pipeline frozen");

endmodule

bind trs_to_matrix trsm_checker u_trsm_checker (.*);
